/* rtl/gate_motor_controller_defines.svh */
// assertion macros used by the rtl
`ifndef GATE_MOTOR_CONTROLLER_DEFINES_SVH
`define GATE_MOTOR_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define GMC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gate controller assertion failed");
`define GMC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("gate controller assertion failed");
`else
`define GMC_ASSERT(label, clk, rst, prop)
`define GMC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* rtl/gmc_pkg.sv */
package gmc_pkg;

   localparam int TICK_COUNTER_WIDTH = 16;
   localparam int CFG_WIDTH          = 16;
   localparam int CSR_INDEX_WIDTH    = 8;
   localparam int REQ_TDATA_WIDTH    = 8;
   localparam int RSP_TDATA_WIDTH    = 8;

   typedef enum logic [2:0] {
      MODE_CLOSED       = 3'd0,
      MODE_OPENING      = 3'd1,
      MODE_OPEN         = 3'd2,
      MODE_OPEN_WAIT    = 3'd3,
      MODE_CLOSING      = 3'd4,
      MODE_AUTO_CLOSING = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_CLOSED = 2'd0,
      STATUS_OPEN   = 2'd1,
      STATUS_MOVING = 2'd2
   } status_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPEN_RUN        = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOSE_LIMIT     = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AUTO_CLOSE_WAIT = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AUTO_CLOSE_RUN  = 8'd3;

   localparam logic [CFG_WIDTH-1:0] OPEN_RUN_RESET        = 16'd50;
   localparam logic [CFG_WIDTH-1:0] CLOSE_LIMIT_RESET     = 16'd50;
   localparam logic [CFG_WIDTH-1:0] AUTO_CLOSE_WAIT_RESET = 16'd100;
   localparam logic [CFG_WIDTH-1:0] AUTO_CLOSE_RUN_RESET  = 16'd50;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] open_run_ticks;
      logic [CFG_WIDTH-1:0] close_limit_ticks;
      logic [CFG_WIDTH-1:0] auto_close_wait_ticks;
      logic [CFG_WIDTH-1:0] auto_close_run_ticks;
   } cfg_type;

   typedef struct packed {
      logic open_button;
      logic close_button;
      logic obstacle;
   } req_type;

   typedef struct packed {
      logic       motor_open_drive;
      logic       motor_close_drive;
      status_type gate_status;
   } rsp_type;

endpackage

/* rtl/gmc_csr.sv */
module gmc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [gmc_pkg::CSR_INDEX_WIDTH-1:0]  wr_index,
   input  logic [gmc_pkg::CFG_WIDTH-1:0]        wr_data,
   output gmc_pkg::cfg_type                     cfg
);

   gmc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_run_ticks        <= gmc_pkg::OPEN_RUN_RESET;
         cfg_ff.close_limit_ticks     <= gmc_pkg::CLOSE_LIMIT_RESET;
         cfg_ff.auto_close_wait_ticks <= gmc_pkg::AUTO_CLOSE_WAIT_RESET;
         cfg_ff.auto_close_run_ticks  <= gmc_pkg::AUTO_CLOSE_RUN_RESET;
      end else if (wr_en) begin
         // indexes past the last register are dropped
         unique case (wr_index)
            gmc_pkg::CSR_OPEN_RUN:        cfg_ff.open_run_ticks        <= wr_data;
            gmc_pkg::CSR_CLOSE_LIMIT:     cfg_ff.close_limit_ticks     <= wr_data;
            gmc_pkg::CSR_AUTO_CLOSE_WAIT: cfg_ff.auto_close_wait_ticks <= wr_data;
            gmc_pkg::CSR_AUTO_CLOSE_RUN:  cfg_ff.auto_close_run_ticks  <= wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/gmc_step.sv */
module gmc_step #(
   parameter int TICK_COUNTER_WIDTH = gmc_pkg::TICK_COUNTER_WIDTH
) (
   input  gmc_pkg::mode_type                mode,
   input  logic [TICK_COUNTER_WIDTH-1:0]    tick_count,
   input  gmc_pkg::req_type                 req,
   input  gmc_pkg::cfg_type                 cfg,
   output gmc_pkg::mode_type                mode_in,
   output logic [TICK_COUNTER_WIDTH-1:0]    tick_in,
   output gmc_pkg::rsp_type                 rsp
);

   localparam int CMP_WIDTH = (TICK_COUNTER_WIDTH > gmc_pkg::CFG_WIDTH) ?
                              TICK_COUNTER_WIDTH : gmc_pkg::CFG_WIDTH;

   logic [TICK_COUNTER_WIDTH-1:0] count_up;
   logic [gmc_pkg::CFG_WIDTH-1:0] limit;
   logic                          reached;
   logic                          open_one_tick;
   logic                          close_one_tick;

   // counter saturates at all ones
   assign count_up = (tick_count == '1) ? tick_count
                                        : tick_count + TICK_COUNTER_WIDTH'(1);

   always_comb begin
      case (mode)
         gmc_pkg::MODE_OPENING:      limit = cfg.open_run_ticks;
         gmc_pkg::MODE_OPEN_WAIT:    limit = cfg.auto_close_wait_ticks;
         gmc_pkg::MODE_CLOSING:      limit = cfg.close_limit_ticks;
         gmc_pkg::MODE_AUTO_CLOSING: limit = cfg.auto_close_run_ticks;
         default:                    limit = '0;
      endcase
   end

   assign reached = CMP_WIDTH'(count_up) >= CMP_WIDTH'(limit);

   // a run started this tick already has a count of one
   assign open_one_tick  = cfg.open_run_ticks <= gmc_pkg::CFG_WIDTH'(1);
   assign close_one_tick = cfg.close_limit_ticks <= gmc_pkg::CFG_WIDTH'(1);

   always_comb begin
      mode_in               = gmc_pkg::MODE_CLOSED;
      tick_in               = '0;
      rsp.motor_open_drive  = 1'b0;
      rsp.motor_close_drive = 1'b0;
      rsp.gate_status       = gmc_pkg::STATUS_CLOSED;
      unique case (mode)
         gmc_pkg::MODE_OPENING: begin
            rsp.motor_open_drive = 1'b1;
            rsp.gate_status      = gmc_pkg::STATUS_MOVING;
            if (reached) begin
               mode_in = gmc_pkg::MODE_OPEN;
            end else begin
               mode_in = gmc_pkg::MODE_OPENING;
               tick_in = count_up;
            end
         end
         gmc_pkg::MODE_OPEN: begin
            if (req.close_button && !req.obstacle) begin
               rsp.motor_close_drive = 1'b1;
               rsp.gate_status       = gmc_pkg::STATUS_MOVING;
               if (!close_one_tick) begin
                  mode_in = gmc_pkg::MODE_CLOSING;
                  tick_in = TICK_COUNTER_WIDTH'(1);
               end
            end else begin
               rsp.gate_status = gmc_pkg::STATUS_OPEN;
               mode_in         = gmc_pkg::MODE_OPEN_WAIT;
            end
         end
         gmc_pkg::MODE_OPEN_WAIT: begin
            rsp.gate_status = gmc_pkg::STATUS_OPEN;
            if (!reached) begin
               mode_in = gmc_pkg::MODE_OPEN_WAIT;
               tick_in = count_up;
            end else if (req.obstacle) begin
               mode_in = gmc_pkg::MODE_OPEN;
            end else begin
               mode_in = gmc_pkg::MODE_AUTO_CLOSING;
            end
         end
         gmc_pkg::MODE_CLOSING: begin
            if (req.obstacle) begin
               rsp.gate_status = gmc_pkg::STATUS_OPEN;
               mode_in         = gmc_pkg::MODE_OPEN;
            end else begin
               rsp.motor_close_drive = 1'b1;
               rsp.gate_status       = gmc_pkg::STATUS_MOVING;
               if (!reached) begin
                  mode_in = gmc_pkg::MODE_CLOSING;
                  tick_in = count_up;
               end
            end
         end
         gmc_pkg::MODE_AUTO_CLOSING: begin
            // blind run, sensor ignored
            rsp.motor_close_drive = 1'b1;
            rsp.gate_status       = gmc_pkg::STATUS_MOVING;
            if (!reached) begin
               mode_in = gmc_pkg::MODE_AUTO_CLOSING;
               tick_in = count_up;
            end
         end
         default: begin
            if (req.open_button) begin
               rsp.motor_open_drive = 1'b1;
               rsp.gate_status      = gmc_pkg::STATUS_MOVING;
               if (open_one_tick) begin
                  mode_in = gmc_pkg::MODE_OPEN;
               end else begin
                  mode_in = gmc_pkg::MODE_OPENING;
                  tick_in = TICK_COUNTER_WIDTH'(1);
               end
            end
         end
      endcase
   end

endmodule

/* rtl/gate_motor_controller.sv */
// a word taken on req passes through the input register and the result register to rsp
// throughput: one word per cycle, with full back-pressure from rsp
// the gate state steps once per word, as it passes into the result register
// reset (synchronous, active high) empties both stages, sets the gate closed
// with a zero tick count and loads the timing registers with their defaults
`include "gate_motor_controller_defines.svh"

module gate_motor_controller #(
   parameter int TICK_COUNTER_WIDTH = gmc_pkg::TICK_COUNTER_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] open_button, [1] close_button, [2] obstacle, [7:3] zero
   input  logic [gmc_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] motor_open_drive, [1] motor_close_drive, [3:2] gate_status, [7:4] zero
   output logic [gmc_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gmc_pkg::CFG_WIDTH-1:0]       csr_data
);

   gmc_pkg::cfg_type              cfg;
   logic                          hold_valid_ff;
   gmc_pkg::req_type              hold_word_ff;
   logic                          res_valid_ff;
   gmc_pkg::rsp_type              res_word_ff;
   gmc_pkg::mode_type             mode_ff;
   gmc_pkg::mode_type             mode_in;
   logic [TICK_COUNTER_WIDTH-1:0] tick_ff;
   logic [TICK_COUNTER_WIDTH-1:0] tick_in;
   gmc_pkg::rsp_type              step_rsp;
   logic                          res_free;
   logic                          advance;

   assign csr_ready = 1'b1;

   gmc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   gmc_step #(
      .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
   ) u_step (
      .mode       (mode_ff),
      .tick_count (tick_ff),
      .req        (hold_word_ff),
      .cfg        (cfg),
      .mode_in    (mode_in),
      .tick_in    (tick_in),
      .rsp        (step_rsp)
   );

   assign res_free   = !res_valid_ff || rsp_tready;
   assign advance    = hold_valid_ff && res_free;
   assign req_tready = !hold_valid_ff || res_free;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_tready) begin
         hold_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         hold_word_ff.open_button  <= req_tdata[0];
         hold_word_ff.close_button <= req_tdata[1];
         hold_word_ff.obstacle     <= req_tdata[2];
      end
   end

   // result stage and gate state
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
         mode_ff      <= gmc_pkg::MODE_CLOSED;
         tick_ff      <= '0;
      end else begin
         if (res_free) begin
            res_valid_ff <= hold_valid_ff;
         end
         if (advance) begin
            mode_ff <= mode_in;
            tick_ff <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_word_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = {{(gmc_pkg::RSP_TDATA_WIDTH - 4){1'b0}},
                        res_word_ff.gate_status,
                        res_word_ff.motor_close_drive,
                        res_word_ff.motor_open_drive};

   `GMC_ASSERT(a_idle_count_zero, clock, reset,
      (mode_ff == gmc_pkg::MODE_CLOSED || mode_ff == gmc_pkg::MODE_OPEN) |-> (tick_ff == '0))
   `GMC_ASSERT(a_state_moves_with_word, clock, reset,
      !advance |=> ($stable(mode_ff) && $stable(tick_ff)))
   `GMC_ASSERT(a_one_direction, clock, reset,
      rsp_tvalid |-> !(res_word_ff.motor_open_drive && res_word_ff.motor_close_drive))
   `GMC_ASSERT(a_moving_iff_driven, clock, reset,
      rsp_tvalid |-> ((res_word_ff.gate_status == gmc_pkg::STATUS_MOVING) ==
                      (res_word_ff.motor_open_drive || res_word_ff.motor_close_drive)))

endmodule
